/* hw/rtl/apn_pkg.sv */
// ----------------------------------------------------------------------------
// apn_pkg: shared types, constants and helpers for average pooling
// Controller commands and status, the register map and geometry helpers.
// ----------------------------------------------------------------------------
package apn_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int MAX_WIDTH   = 1024;
    localparam int COL_BITS    = 10;
    localparam int CH_BITS     = 6;
    localparam int SLOT_BITS   = 3;
    localparam int ADDR_BITS   = SLOT_BITS + COL_BITS + CH_BITS;
    localparam int DIV_BITS    = 23;
    localparam int REM_BITS    = 7;
    localparam int CFG_BITS    = 12;

    localparam logic [4:0] GEO_STEPS = 5'd11;
    localparam logic [4:0] AVG_STEPS = 5'd23;

    // register map
    typedef enum logic [2:0] {
        CFG_IN_HEIGHT   = 3'd0,
        CFG_IN_WIDTH    = 3'd1,
        CFG_CHANNELS    = 3'd2,
        CFG_KERNEL_ROWS = 3'd3,
        CFG_KERNEL_COLS = 3'd4,
        CFG_STRIDE_ROWS = 3'd5,
        CFG_STRIDE_COLS = 3'd6,
        CFG_PADDING     = 3'd7
    } t_cfg_idx;

    typedef enum logic [1:0] {
        DIV_SPAN_END = 2'd0,
        DIV_SPAN_POS = 2'd1,
        DIV_AVERAGE  = 2'd2
    } t_div_sel;

    typedef enum logic [3:0] {
        S_IDLE, S_DIVA, S_WAITA, S_DIVB, S_WAITB, S_SPAN, S_MUL,
        S_BND, S_SWEEP, S_DRAIN, S_AVG, S_WAITV, S_EMIT
    } t_state;

    typedef struct packed {
        logic     accept;
        logic     div_start;
        t_div_sel div_sel;
        logic     latch_a;
        logic     span;
        logic     win_mul;
        logic     win_bnd;
        logic     sweep;
        logic     emit;
    } t_cmd;

    typedef struct packed {
        logic div_busy;
        logic span_empty;
        logic sweep_last;
        logic out_free;
        logic win_last;
    } t_sts;

    typedef struct packed {
        logic [10:0] first;
        logic [10:0] last;
        logic        empty;
    } t_span;

    // dimension held to 1..1024
    function automatic logic [10:0] f_clamp_dim(input logic [10:0] v);
        if (v == 11'd0) return 11'd1;
        if (v > 11'd1024) return 11'd1024;
        return v;
    endfunction

    function automatic logic [6:0] f_clamp_ch(input logic [6:0] v);
        if (v == 7'd0) return 7'd1;
        if (v > 7'd64) return 7'd64;
        return v;
    endfunction

    function automatic logic [3:0] f_clamp_k(input logic [3:0] v);
        if (v == 4'd0) return 4'd1;
        if (v > 4'd8) return 4'd8;
        return v;
    endfunction

    // pad saturated to kernel minus one
    function automatic logic [2:0] f_sat_pad(input logic [2:0] p, input logic [3:0] k);
        logic [3:0] km1;
        km1 = k - 4'd1;
        if ({1'b0, p} > km1) return km1[2:0];
        return p;
    endfunction

    // windows in one direction whose last real position is p
    function automatic t_span f_span(
        input logic [10:0] p,
        input logic [10:0] n,
        input logic        has,
        input logic        t_neg,
        input logic        t_zero,
        input logic [10:0] qa,
        input logic [10:0] qb,
        input logic [6:0]  rem
    );
        t_span      s;
        logic [11:0] nout;
        nout    = {1'b0, qa} + 12'd1;
        s.first = '0;
        s.last  = '0;
        s.empty = 1'b1;
        if (has) begin
            if ({1'b0, p} + 12'd1 < {1'b0, n}) begin
                s.first = qb;
                s.last  = qb;
                s.empty = t_neg || (rem != '0) || ({1'b0, qb} >= nout);
            end else begin
                s.first = (t_neg || t_zero) ? 11'd0 : qb + 11'(rem != '0);
                s.last  = qa;
                s.empty = s.first > qa;
            end
        end
        return s;
    endfunction

endpackage

/* hw/rtl/apn_div.sv */
// ----------------------------------------------------------------------------
// apn_div: restoring divider, one quotient bit per cycle
// Runs a given number of steps over the low bits of the dividend.
// ----------------------------------------------------------------------------
module apn_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [4:0]                    i_steps,
    input  logic [apn_pkg::DIV_BITS-1:0]  i_dividend,
    input  logic [apn_pkg::REM_BITS-1:0]  i_divisor,
    output logic                          o_busy,
    output logic [apn_pkg::DIV_BITS-1:0]  o_quot,
    output logic [apn_pkg::REM_BITS-1:0]  o_rem
);
    import apn_pkg::*;

    logic                r_busy;
    logic [4:0]          r_cnt;
    logic [REM_BITS-1:0] r_rem;
    logic [REM_BITS-1:0] r_dvs;
    logic [DIV_BITS-1:0] r_quo;
    logic [REM_BITS:0]   w_part;
    logic                w_ge;

    // trial subtract of the next partial remainder
    always_comb begin
        w_part = {r_rem, r_quo[DIV_BITS-1]};
        w_ge   = w_part >= {1'b0, r_dvs};
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= i_steps != 5'd0;
            r_cnt  <= i_steps;
        end else if (r_busy) begin
            r_busy <= r_cnt != 5'd1;
            r_cnt  <= r_cnt - 5'd1;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvs <= i_divisor;
            r_quo <= i_dividend << (5'(DIV_BITS) - i_steps);
        end else if (r_busy) begin
            r_rem <= w_ge ? REM_BITS'(w_part - {1'b0, r_dvs}) : w_part[REM_BITS-1:0];
            r_quo <= {r_quo[DIV_BITS-2:0], w_ge};
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_quo;
    assign o_rem  = r_rem;

endmodule

/* hw/rtl/apn_dp.sv */
// ----------------------------------------------------------------------------
// apn_dp: pooling datapath
// Registers, position, row store, window geometry, sum and output register.
// ----------------------------------------------------------------------------
module apn_dp (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [2:0]                       i_cfg_index,
    input  logic [apn_pkg::CFG_BITS-1:0]     i_cfg_data,
    input  logic signed [apn_pkg::SAMPLE_BITS-1:0] i_sample,
    input  apn_pkg::t_cmd                    i_cmd,
    output apn_pkg::t_sts                    o_sts,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic signed [apn_pkg::SAMPLE_BITS-1:0] o_average,
    output logic [10:0]                      o_out_row,
    output logic [10:0]                      o_out_col,
    output logic [5:0]                       o_channel_index,
    output logic                             o_run_last,
    output logic                             o_image_last
);
    import apn_pkg::*;

    // configuration registers
    logic [10:0] r_in_height, r_in_width;
    logic [6:0]  r_channels;
    logic [3:0]  r_kr_raw, r_kc_raw, r_sr_raw, r_sc_raw;
    logic [11:0] r_padding;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_height <= 11'd8;
            r_in_width  <= 11'd8;
            r_channels  <= 7'd1;
            r_kr_raw    <= 4'd2;
            r_kc_raw    <= 4'd2;
            r_sr_raw    <= 4'd2;
            r_sc_raw    <= 4'd2;
            r_padding   <= 12'd0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_IN_HEIGHT:   r_in_height <= i_cfg_data[10:0];
                CFG_IN_WIDTH:    r_in_width  <= i_cfg_data[10:0];
                CFG_CHANNELS:    r_channels  <= i_cfg_data[6:0];
                CFG_KERNEL_ROWS: r_kr_raw    <= i_cfg_data[3:0];
                CFG_KERNEL_COLS: r_kc_raw    <= i_cfg_data[3:0];
                CFG_STRIDE_ROWS: r_sr_raw    <= i_cfg_data[3:0];
                CFG_STRIDE_COLS: r_sc_raw    <= i_cfg_data[3:0];
                CFG_PADDING:     r_padding   <= i_cfg_data;
                default:         r_padding   <= r_padding;
            endcase
        end
    end

    // effective geometry
    logic [10:0] w_h, w_w;
    logic [6:0]  w_c;
    logic [3:0]  w_kr, w_kc, w_sr, w_sc;
    logic [2:0]  w_pt, w_pb, w_pl, w_pr;

    always_comb begin
        w_h  = f_clamp_dim(r_in_height);
        w_w  = f_clamp_dim(r_in_width);
        w_c  = f_clamp_ch(r_channels);
        w_kr = f_clamp_k(r_kr_raw);
        w_kc = f_clamp_k(r_kc_raw);
        w_sr = f_clamp_k(r_sr_raw);
        w_sc = f_clamp_k(r_sc_raw);
        w_pt = f_sat_pad(r_padding[2:0], w_kr);
        w_pb = f_sat_pad(r_padding[5:3], w_kr);
        w_pl = f_sat_pad(r_padding[8:6], w_kc);
        w_pr = f_sat_pad(r_padding[11:9], w_kc);
    end

    // stream position, wrapped when beyond the geometry
    logic [10:0] r_pos_row, r_pos_col;
    logic [5:0]  r_pos_ch;
    logic [10:0] r_prow, r_pcol;
    logic [5:0]  r_ch;
    logic        w_wrap;
    logic [10:0] w_er, w_ec;
    logic [5:0]  w_ech;
    logic [6:0]  w_nch;
    logic [10:0] w_ncol, w_nrow;

    always_comb begin
        w_wrap = (r_pos_row >= w_h) || (r_pos_col >= w_w) || ({1'b0, r_pos_ch} >= w_c);
        w_er   = w_wrap ? 11'd0 : r_pos_row;
        w_ec   = w_wrap ? 11'd0 : r_pos_col;
        w_ech  = w_wrap ? 6'd0 : r_pos_ch;
        w_nch  = {1'b0, w_ech} + 7'd1;
        w_ncol = w_ec;
        w_nrow = w_er;
        if (w_nch >= w_c) begin
            w_nch  = 7'd0;
            w_ncol = w_ec + 11'd1;
            if (w_ncol >= w_w) begin
                w_ncol = 11'd0;
                w_nrow = w_er + 11'd1;
                if (w_nrow >= w_h) w_nrow = 11'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_row <= '0;
            r_pos_col <= '0;
            r_pos_ch  <= '0;
        end else if (i_cmd.accept) begin
            r_pos_row <= w_nrow;
            r_pos_col <= w_ncol;
            r_pos_ch  <= w_nch[5:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_prow <= w_er;
            r_pcol <= w_ec;
            r_ch   <= w_ech;
        end
    end

    // row store: eight row slots of width by channels
    logic signed [SAMPLE_BITS-1:0] r_mem [2**ADDR_BITS];
    logic signed [SAMPLE_BITS-1:0] r_rdata;
    logic [10:0]          r_ir, r_ic;
    logic [ADDR_BITS-1:0] w_waddr, w_raddr;

    assign w_waddr = {w_er[SLOT_BITS-1:0], w_ec[COL_BITS-1:0], w_ech};
    assign w_raddr = {r_ir[SLOT_BITS-1:0], r_ic[COL_BITS-1:0], r_ch};

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) r_mem[w_waddr] <= i_sample;
        if (i_cmd.sweep) r_rdata <= r_mem[w_raddr];
    end

    // per-direction dividends
    logic [11:0] w_ext_r, w_ext_c;
    logic        w_has_r, w_has_c;
    logic [12:0] w_ts_r, w_ts_c;
    logic        w_tneg_r, w_tneg_c, w_tz_r, w_tz_c;
    logic [10:0] w_da_r, w_da_c, w_db_r, w_db_c;

    always_comb begin
        w_ext_r  = {1'b0, w_h} + 12'(w_pt) + 12'(w_pb);
        w_ext_c  = {1'b0, w_w} + 12'(w_pl) + 12'(w_pr);
        w_has_r  = w_ext_r >= 12'(w_kr);
        w_has_c  = w_ext_c >= 12'(w_kc);
        w_da_r   = w_has_r ? 11'(w_ext_r - 12'(w_kr)) : 11'd0;
        w_da_c   = w_has_c ? 11'(w_ext_c - 12'(w_kc)) : 11'd0;
        w_ts_r   = {2'b0, r_prow} + 13'(w_pt) + 13'd1;
        w_ts_c   = {2'b0, r_pcol} + 13'(w_pl) + 13'd1;
        w_tneg_r = w_ts_r < 13'(w_kr);
        w_tneg_c = w_ts_c < 13'(w_kc);
        w_tz_r   = w_ts_r == 13'(w_kr);
        w_tz_c   = w_ts_c == 13'(w_kc);
        w_db_r   = w_tneg_r ? 11'd0 : 11'(w_ts_r - 13'(w_kr));
        w_db_c   = w_tneg_c ? 11'd0 : 11'(w_ts_c - 13'(w_kc));
    end

    // dividers: rows and averages share the first one
    logic [DIV_BITS-1:0] w_dvd0, w_dvd1, w_q0, w_q1;
    logic [REM_BITS-1:0] w_dvs0, w_rem0, w_rem1;
    logic [4:0]          w_steps0;
    logic                w_busy0, w_busy1, w_start1;
    logic signed [DIV_BITS-1:0] r_sum;
    logic [DIV_BITS-2:0] w_mag;
    logic [10:0] r_rs, r_re, r_cs, r_ce;
    logic [6:0]  w_cnt;

    always_comb begin
        w_mag = r_sum[DIV_BITS-1] ? (DIV_BITS-1)'(-r_sum) : (DIV_BITS-1)'(r_sum);
        w_cnt = 7'((r_re - r_rs + 11'd1) * (r_ce - r_cs + 11'd1));
        unique case (i_cmd.div_sel)
            DIV_SPAN_END: begin
                w_dvd0   = DIV_BITS'(w_da_r);
                w_dvd1   = DIV_BITS'(w_da_c);
                w_dvs0   = 7'(w_sr);
                w_steps0 = GEO_STEPS;
            end
            DIV_SPAN_POS: begin
                w_dvd0   = DIV_BITS'(w_db_r);
                w_dvd1   = DIV_BITS'(w_db_c);
                w_dvs0   = 7'(w_sr);
                w_steps0 = GEO_STEPS;
            end
            default: begin
                w_dvd0   = DIV_BITS'(w_mag) + DIV_BITS'(w_cnt >> 1);
                w_dvd1   = '0;
                w_dvs0   = w_cnt;
                w_steps0 = AVG_STEPS;
            end
        endcase
        w_start1 = i_cmd.div_start && (i_cmd.div_sel != DIV_AVERAGE);
    end

    apn_div u_div0 (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_steps    (w_steps0),
        .i_dividend (w_dvd0),
        .i_divisor  (w_dvs0),
        .o_busy     (w_busy0),
        .o_quot     (w_q0),
        .o_rem      (w_rem0)
    );

    apn_div u_div1 (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start1),
        .i_steps    (GEO_STEPS),
        .i_dividend (w_dvd1),
        .i_divisor  (7'(w_sc)),
        .o_busy     (w_busy1),
        .o_quot     (w_q1),
        .o_rem      (w_rem1)
    );

    // window ranges of this sample
    logic [10:0] r_qa_r, r_qa_c;
    t_span       w_span_r, w_span_c;
    logic [10:0] r_oh1, r_ow0, r_ow1, r_oh, r_ow;

    always_comb begin
        w_span_r = f_span(r_prow, w_h, w_has_r, w_tneg_r, w_tz_r, r_qa_r,
                          w_q0[10:0], w_rem0);
        w_span_c = f_span(r_pcol, w_w, w_has_c, w_tneg_c, w_tz_c, r_qa_c,
                          w_q1[10:0], w_rem1);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_a) begin
            r_qa_r <= w_q0[10:0];
            r_qa_c <= w_q1[10:0];
        end
    end

    // window walk in row then column order
    logic w_win_last;
    assign w_win_last = (r_oh == r_oh1) && (r_ow == r_ow1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.span) begin
            r_oh1 <= w_span_r.last;
            r_ow0 <= w_span_c.first;
            r_ow1 <= w_span_c.last;
            r_oh  <= w_span_r.first;
            r_ow  <= w_span_c.first;
        end else if (i_cmd.emit) begin
            if (r_ow == r_ow1) begin
                r_ow <= r_ow0;
                r_oh <= r_oh + 11'd1;
            end else begin
                r_ow <= r_ow + 11'd1;
            end
        end
    end

    // window origin, then clipped bounds
    logic signed [15:0] r_h0, r_w0;
    logic signed [15:0] w_hend, w_wend;

    always_comb begin
        w_hend = r_h0 + 16'(w_kr) - 16'sd1;
        w_wend = r_w0 + 16'(w_kc) - 16'sd1;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.win_mul) begin
            r_h0 <= signed'(16'(r_oh * w_sr)) - signed'(16'(w_pt));
            r_w0 <= signed'(16'(r_ow * w_sc)) - signed'(16'(w_pl));
        end
        if (i_cmd.win_bnd) begin
            r_rs <= r_h0[15] ? 11'd0 : r_h0[10:0];
            r_cs <= r_w0[15] ? 11'd0 : r_w0[10:0];
            r_re <= (w_hend > signed'(16'(w_h)) - 16'sd1) ? w_h - 11'd1 : w_hend[10:0];
            r_ce <= (w_wend > signed'(16'(w_w)) - 16'sd1) ? w_w - 11'd1 : w_wend[10:0];
        end
    end

    // sweep over the window and accumulate
    logic r_rd_vld;
    logic w_sweep_last;
    assign w_sweep_last = (r_ir == r_re) && (r_ic == r_ce);

    always_ff @(posedge i_clk) begin
        if (i_cmd.win_bnd) begin
            r_ir <= r_h0[15] ? 11'd0 : r_h0[10:0];
            r_ic <= r_w0[15] ? 11'd0 : r_w0[10:0];
        end else if (i_cmd.sweep) begin
            if (r_ic == r_ce) begin
                r_ic <= r_cs;
                r_ir <= r_ir + 11'd1;
            end else begin
                r_ic <= r_ic + 11'd1;
            end
        end
        if (i_cmd.win_bnd) r_sum <= '0;
        else if (r_rd_vld) r_sum <= r_sum + DIV_BITS'(r_rdata);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_rd_vld <= 1'b0;
        else r_rd_vld <= i_cmd.sweep;
    end

    // output register
    logic        r_o_valid;
    logic signed [SAMPLE_BITS-1:0] r_avg;
    logic [10:0] r_o_row, r_o_col;
    logic [5:0]  r_o_ch;
    logic        r_o_run, r_o_img;
    logic        w_out_free;

    assign w_out_free = !r_o_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_o_valid <= 1'b0;
        else if (i_cmd.emit) r_o_valid <= 1'b1;
        else if (!i_out_stall) r_o_valid <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_avg   <= r_sum[DIV_BITS-1] ? SAMPLE_BITS'(-w_q0) : SAMPLE_BITS'(w_q0);
            r_o_row <= r_oh;
            r_o_col <= r_ow;
            r_o_ch  <= r_ch;
            r_o_run <= w_win_last;
            r_o_img <= (r_oh == r_qa_r) && (r_ow == r_qa_c) && ({1'b0, r_ch} == w_c - 7'd1);
        end
    end

    // status to the controller
    always_comb begin
        o_sts.div_busy   = w_busy0 || w_busy1;
        o_sts.span_empty = w_span_r.empty || w_span_c.empty;
        o_sts.sweep_last = w_sweep_last;
        o_sts.out_free   = w_out_free;
        o_sts.win_last   = w_win_last;
    end

    assign o_out_valid     = r_o_valid;
    assign o_average       = r_avg;
    assign o_out_row       = r_o_row;
    assign o_out_col       = r_o_col;
    assign o_channel_index = r_o_ch;
    assign o_run_last      = r_o_run;
    assign o_image_last    = r_o_img;

endmodule

/* hw/rtl/apn_ctrl.sv */
// ----------------------------------------------------------------------------
// apn_ctrl: pooling controller
// Sequences geometry divides, the window walk, the sweep and the output.
// ----------------------------------------------------------------------------
module apn_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  apn_pkg::t_sts i_sts,
    output apn_pkg::t_cmd o_cmd
);
    import apn_pkg::*;

    t_state r_state, n_state;
    t_cmd   w_cmd;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else r_state <= n_state;
    end

    // next state and commands
    always_comb begin
        n_state       = r_state;
        w_cmd         = '0;
        w_cmd.div_sel = DIV_SPAN_END;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    w_cmd.accept = 1'b1;
                    n_state      = S_DIVA;
                end
            end
            S_DIVA: begin
                w_cmd.div_start = 1'b1;
                n_state         = S_WAITA;
            end
            S_WAITA: if (!i_sts.div_busy) n_state = S_DIVB;
            S_DIVB: begin
                w_cmd.latch_a   = 1'b1;
                w_cmd.div_start = 1'b1;
                w_cmd.div_sel   = DIV_SPAN_POS;
                n_state         = S_WAITB;
            end
            S_WAITB: if (!i_sts.div_busy) n_state = S_SPAN;
            S_SPAN: begin
                w_cmd.span = 1'b1;
                n_state    = i_sts.span_empty ? S_IDLE : S_MUL;
            end
            S_MUL: begin
                w_cmd.win_mul = 1'b1;
                n_state       = S_BND;
            end
            S_BND: begin
                w_cmd.win_bnd = 1'b1;
                n_state       = S_SWEEP;
            end
            S_SWEEP: begin
                w_cmd.sweep = 1'b1;
                if (i_sts.sweep_last) n_state = S_DRAIN;
            end
            S_DRAIN: n_state = S_AVG;
            S_AVG: begin
                w_cmd.div_start = 1'b1;
                w_cmd.div_sel   = DIV_AVERAGE;
                n_state         = S_WAITV;
            end
            S_WAITV: if (!i_sts.div_busy) n_state = S_EMIT;
            S_EMIT: begin
                if (i_sts.out_free) begin
                    w_cmd.emit = 1'b1;
                    n_state    = i_sts.win_last ? S_IDLE : S_MUL;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_cmd      = w_cmd;
    assign o_in_stall = r_state != S_IDLE;

    // checks
    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.div_start |-> !i_sts.div_busy)
        else $error("divider restarted while busy");
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit |-> i_sts.out_free)
        else $error("result loaded over a waiting result");
    a_sweep_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.sweep && i_sts.sweep_last) |=> !w_cmd.sweep)
        else $error("sweep ran past the window");
    a_busy_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.accept |=> o_in_stall)
        else $error("second request taken while first in work");

endmodule

/* hw/rtl/avg_pool_2d_nhwc.sv */
// ----------------------------------------------------------------------------
// avg_pool_2d_nhwc: streaming 2-D average pooling, padding excluded
// Top level joining the controller and the datapath.
// ----------------------------------------------------------------------------
// Usage:
//   input channel: i_in_valid / o_in_stall carry one Q8.8 sample per request,
//   in row, column, channel order; images follow back to back.
//   output channel: o_out_valid / i_out_stall carry one window average with
//   its row, column, channel and the run and image end flags.
//   configuration: i_cfg_we writes i_cfg_data to register i_cfg_index;
//   the user writes only while the block is idle, not enforced by the block.
// Sequence:
//   a sample that closes no window needs two geometry divides of 11 steps
//   and the wait for each divider to finish.
//   each closed window adds its control states plus one store read per real
//   sample in the window, plus an average divide, one result per window.
//   one sample is in work at a time; a result waiting in the output register
//   does not block the next sample until its own first result is ready.
// Reset: synchronous; registers return to 8x8, one channel, 2x2 kernel,
//   stride 2, no padding; position returns to the start of an image.
// Stall: a stalled result holds; the block waits with its next result.
// ----------------------------------------------------------------------------
module avg_pool_2d_nhwc (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [2:0]                     i_cfg_index,
    input  logic [apn_pkg::CFG_BITS-1:0]   i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic signed [apn_pkg::SAMPLE_BITS-1:0] i_sample,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic signed [apn_pkg::SAMPLE_BITS-1:0] o_average,
    output logic [10:0]                    o_out_row,
    output logic [10:0]                    o_out_col,
    output logic [5:0]                     o_channel_index,
    output logic                           o_run_last,
    output logic                           o_image_last
);
    import apn_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    // sequencer
    apn_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // store, geometry and arithmetic
    apn_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_sample        (i_sample),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_average       (o_average),
        .o_out_row       (o_out_row),
        .o_out_col       (o_out_col),
        .o_channel_index (o_channel_index),
        .o_run_last      (o_run_last),
        .o_image_last    (o_image_last)
    );

endmodule

/* verif/tb_avg_pool_2d_nhwc.sv */
// ----------------------------------------------------------------------------
// tb_avg_pool_2d_nhwc: self-checking bench for streaming average pooling
// Sends Q8.8 samples in row, column, channel order through several window
// geometries and compares every window average against an in-bench pooling
// model, under varying sender gaps and output stalls.
// ----------------------------------------------------------------------------
module tb_avg_pool_2d_nhwc;
    import apn_pkg::*;

    typedef struct {
        logic signed [15:0] average;
        logic [10:0]        out_row;
        logic [10:0]        out_col;
        logic [5:0]         channel_index;
        logic               run_last;
        logic               image_last;
    } t_window_avg;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [2:0]             i_cfg_index = '0;
    logic [CFG_BITS-1:0]    i_cfg_data = '0;
    logic                   i_in_valid = 1'b0;
    logic                   o_in_stall;
    logic signed [15:0]     i_sample = '0;
    logic                   o_out_valid;
    logic                   i_out_stall = 1'b0;
    logic signed [15:0]     o_average;
    logic [10:0]            o_out_row;
    logic [10:0]            o_out_col;
    logic [5:0]             o_channel_index;
    logic                   o_run_last;
    logic                   o_image_last;

    // pooling model state
    logic signed [15:0]     pooled_rows [0:524287];
    int                     cur_row, cur_col, cur_ch;
    int unsigned            geom_regs [8];
    t_window_avg            pending_avgs [$];

    int                     mismatches = 0;
    int                     samples_sent = 0;
    int                     send_gap_pct = 0;
    int                     out_stall_pct = 0;

    avg_pool_2d_nhwc dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_sample        (i_sample),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_average       (o_average),
        .o_out_row       (o_out_row),
        .o_out_col       (o_out_col),
        .o_channel_index (o_channel_index),
        .o_run_last      (o_run_last),
        .o_image_last    (o_image_last)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic int clamp_int(int v, int lo, int hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic int pool_addr(int r, int c, int ch);
        return (((r % 8) * 1024 + c) * 64 + ch) % 524288;
    endfunction

    // range of windows along one axis closed by position p
    function automatic void closed_windows(input int p, input int n, input int pa,
                                           input int pb, input int k, input int s,
                                           output int first, output int last,
                                           output int nout);
        int t;
        t = p + pa + 1 - k;
        nout = (n + pa + pb >= k) ? (n + pa + pb - k) / s + 1 : 0;
        first = 0;
        last = -1;
        if (nout == 0) return;
        if (p < n - 1) begin
            if (t >= 0 && t % s == 0 && t / s < nout) begin
                first = t / s;
                last = t / s;
            end
        end else begin
            first = (t <= 0) ? 0 : (t + s - 1) / s;
            last = nout - 1;
        end
    endfunction

    // store one sample and queue the window averages it completes
    function automatic void pool_sample(logic signed [15:0] v);
        int hgt, wid, nch, kr, kc, sr, sc, pt, pb, pl, pr;
        int oh0, oh1, ow0, ow1, hout, wout, rs, re, cs, ce, h0, w0, n, made;
        longint sum, mag, q;
        t_window_avg w;
        hgt = clamp_int(geom_regs[CFG_IN_HEIGHT], 1, 1024);
        wid = clamp_int(geom_regs[CFG_IN_WIDTH], 1, 1024);
        nch = clamp_int(geom_regs[CFG_CHANNELS], 1, 64);
        kr  = clamp_int(geom_regs[CFG_KERNEL_ROWS], 1, 8);
        kc  = clamp_int(geom_regs[CFG_KERNEL_COLS], 1, 8);
        sr  = clamp_int(geom_regs[CFG_STRIDE_ROWS], 1, 8);
        sc  = clamp_int(geom_regs[CFG_STRIDE_COLS], 1, 8);
        pt  = clamp_int(geom_regs[CFG_PADDING] & 7, 0, kr - 1);
        pb  = clamp_int((geom_regs[CFG_PADDING] >> 3) & 7, 0, kr - 1);
        pl  = clamp_int((geom_regs[CFG_PADDING] >> 6) & 7, 0, kc - 1);
        pr  = clamp_int((geom_regs[CFG_PADDING] >> 9) & 7, 0, kc - 1);
        made = 0;
        if (cur_row >= hgt || cur_col >= wid || cur_ch >= nch) begin
            cur_row = 0;
            cur_col = 0;
            cur_ch = 0;
        end
        pooled_rows[pool_addr(cur_row, cur_col, cur_ch)] = v;
        closed_windows(cur_row, hgt, pt, pb, kr, sr, oh0, oh1, hout);
        closed_windows(cur_col, wid, pl, pr, kc, sc, ow0, ow1, wout);
        for (int oh = oh0; oh <= oh1; oh++) begin
            h0 = oh * sr - pt;
            rs = (h0 < 0) ? 0 : h0;
            re = (h0 + kr - 1 < hgt - 1) ? h0 + kr - 1 : hgt - 1;
            for (int ow = ow0; ow <= ow1; ow++) begin
                w0 = ow * sc - pl;
                cs = (w0 < 0) ? 0 : w0;
                ce = (w0 + kc - 1 < wid - 1) ? w0 + kc - 1 : wid - 1;
                sum = 0;
                for (int ir = rs; ir <= re; ir++)
                    for (int ic = cs; ic <= ce; ic++)
                        sum += pooled_rows[pool_addr(ir, ic, cur_ch)];
                n = (re - rs + 1) * (ce - cs + 1);
                if (n < 1) n = 1;
                // round half away from zero on the magnitude
                mag = (sum < 0) ? -sum : sum;
                q = (mag + n / 2) / n;
                if (made >= 64) continue;
                w.average = (sum < 0) ? 16'(-q) : 16'(q);
                w.out_row = 11'(oh);
                w.out_col = 11'(ow);
                w.channel_index = 6'(cur_ch);
                w.run_last = 1'b0;
                w.image_last = (oh == hout - 1 && ow == wout - 1 && cur_ch == nch - 1);
                pending_avgs.push_back(w);
                made++;
            end
        end
        if (made > 0) pending_avgs[pending_avgs.size() - 1].run_last = 1'b1;
        // advance the raster position
        cur_ch++;
        if (cur_ch >= nch) begin
            cur_ch = 0;
            cur_col++;
            if (cur_col >= wid) begin
                cur_col = 0;
                cur_row++;
                if (cur_row >= hgt) cur_row = 0;
            end
        end
    endfunction

    // write all eight geometry registers back to back
    task automatic program_geometry(input int unsigned vals [8]);
        for (int i = 0; i < 8; i++) begin
            i_cfg_we <= 1'b1;
            i_cfg_index <= 3'(i);
            i_cfg_data <= CFG_BITS'(vals[i]);
            @(posedge i_clk);
            geom_regs[i] = (i == CFG_IN_HEIGHT || i == CFG_IN_WIDTH) ? vals[i] & 11'h7ff :
                           (i == CFG_CHANNELS) ? vals[i] & 7'h7f :
                           (i == CFG_PADDING) ? vals[i] & 12'hfff : vals[i] & 4'hf;
        end
        i_cfg_we <= 1'b0;
    endtask

    // one sample request, with random gaps before it
    task automatic send_sample(input logic signed [15:0] v);
        while ($urandom_range(99) < send_gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_sample <= v;
        do @(posedge i_clk); while (o_in_stall);
        pool_sample(v);
        samples_sent++;
    endtask

    // wait out every expected average, then the block's own latency
    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_avgs.size() > 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    function automatic logic signed [15:0] rand_sample();
        case ($urandom_range(9))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            default: return 16'($urandom);
        endcase
    endfunction

    // output side: random stalls and comparison against the oldest expectation
    always @(posedge i_clk) begin
        t_window_avg exp_avg;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= ($urandom_range(99) < out_stall_pct);
            if (o_out_valid && !i_out_stall) begin
                if (pending_avgs.size() == 0) begin
                    if (mismatches < 10)
                        $display("unexpected average %0d at row %0d col %0d ch %0d",
                                 o_average, o_out_row, o_out_col, o_channel_index);
                    mismatches++;
                end else begin
                    exp_avg = pending_avgs.pop_front();
                    if (o_average !== exp_avg.average || o_out_row !== exp_avg.out_row ||
                        o_out_col !== exp_avg.out_col ||
                        o_channel_index !== exp_avg.channel_index ||
                        o_run_last !== exp_avg.run_last ||
                        o_image_last !== exp_avg.image_last) begin
                        if (mismatches < 10)
                            $display("exp avg %0d r%0d c%0d ch%0d rl%0b il%0b / got %0d r%0d c%0d ch%0d rl%0b il%0b",
                                     exp_avg.average, exp_avg.out_row, exp_avg.out_col,
                                     exp_avg.channel_index, exp_avg.run_last,
                                     exp_avg.image_last, o_average, o_out_row, o_out_col,
                                     o_channel_index, o_run_last, o_image_last);
                        mismatches++;
                    end
                end
            end
        end
    end

    // padded 3x3 image, two channels, overlapping 2x2 windows, full-scale values
    task automatic test_padded_extremes();
        int unsigned g [8];
        logic signed [15:0] vals [18];
        g = '{3, 3, 2, 2, 2, 1, 1, 12'b001_001_001_001};
        vals = '{16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000,
                 16'sh0001, 16'shffff, 16'sh0002, 16'shfffe, 16'sh0000, 16'sh0001,
                 16'sh0003, 16'shfffd, 16'sh7ffe, 16'sh8001, 16'sh0100, 16'shff00};
        send_gap_pct = 0;
        out_stall_pct = 0;
        program_geometry(g);
        foreach (vals[i]) send_sample(vals[i]);
        drain();
    endtask

    // kernel taller than the image: samples are taken but no window closes
    task automatic test_kernel_exceeds_image();
        int unsigned g [8];
        g = '{3, 2, 1, 8, 8, 1, 1, 0};
        send_gap_pct = 35;
        out_stall_pct = 35;
        program_geometry(g);
        repeat (6) send_sample(rand_sample());
        drain();
    endtask

    // out-of-range register values: full-size frame, 64 channels, 1x1 windows
    task automatic test_full_size_frame();
        int unsigned g [8];
        g = '{2047, 2047, 127, 1, 1, 1, 1, 12'hfff};
        send_gap_pct = 80;
        out_stall_pct = 0;
        program_geometry(g);
        repeat (70) send_sample(rand_sample());
        drain();
    endtask

    // largest kernel and stride with random padding
    task automatic test_max_kernel_stride();
        int unsigned g [8];
        g = '{9, 9, 1, 15, 15, 15, 15, $urandom_range(4095)};
        send_gap_pct = 0;
        out_stall_pct = 80;
        program_geometry(g);
        repeat (81) send_sample(rand_sample());
        drain();
    endtask

    // whole images on random small geometries, idling pattern rotated per geometry
    task automatic test_random_geometry();
        int unsigned g [8];
        int phase, images;
        phase = 0;
        while (samples_sent < 280) begin
            g[CFG_IN_HEIGHT] = $urandom_range(5, 1);
            g[CFG_IN_WIDTH] = $urandom_range(5, 1);
            g[CFG_CHANNELS] = $urandom_range(3, 1);
            g[CFG_KERNEL_ROWS] = $urandom_range(4);
            g[CFG_KERNEL_COLS] = $urandom_range(4);
            g[CFG_STRIDE_ROWS] = $urandom_range(4);
            g[CFG_STRIDE_COLS] = $urandom_range(4);
            g[CFG_PADDING] = $urandom_range(4095);
            images = $urandom_range(2, 1);
            case (phase % 4)
                0: begin send_gap_pct = 0;  out_stall_pct = 0;  end
                1: begin send_gap_pct = 80; out_stall_pct = 0;  end
                2: begin send_gap_pct = 0;  out_stall_pct = 80; end
                default: begin send_gap_pct = 35; out_stall_pct = 35; end
            endcase
            program_geometry(g);
            repeat (images * g[CFG_IN_HEIGHT] * g[CFG_IN_WIDTH] * g[CFG_CHANNELS])
                send_sample(rand_sample());
            drain();
            phase++;
        end
    endtask

    initial begin
        cur_row = 0;
        cur_col = 0;
        cur_ch = 0;
        geom_regs = '{8, 8, 1, 2, 2, 2, 2, 0};
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_padded_extremes();
        test_kernel_exceeds_image();
        test_full_size_frame();
        test_max_kernel_stride();
        test_random_geometry();
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // run limit
    initial begin
        #(12 * 3000000);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
